// ===== rtl/pls_pkg.sv =====
// Shared types, constants and the per-byte rating function for the plaintext scorer.
// No dependencies; used by pls_front, pls_queue, pls_back and the checker.
package pls_pkg;

    // Buffer length the saturation bound is sized for
    localparam int MAX_BYTES = 65536;
    localparam int BOUND     = (10 * MAX_BYTES > 1048575) ? 1048575 : 10 * MAX_BYTES;

    // Work queue sizing
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One rating is -10..+10
    typedef logic signed [4:0] t_rating;

    localparam t_rating R_CTRL  = -5'sd4;
    localparam t_rating R_TRIP  = -5'sd5;
    localparam t_rating R_PAIR  = -5'sd2;
    localparam t_rating R_GLUE  = -5'sd10;
    localparam t_rating R_WORD  = 5'sd10;
    localparam t_rating R_PUNCT = -5'sd2;
    localparam t_rating R_NONE  = 5'sd0;

    // Request passed from front to back: up to three ratings, packed from slot 0
    typedef struct packed {
        t_rating [2:0] d;
        logic [1:0]    n;
        logic          last;
    } t_work;

    function automatic logic is_letter(input logic [7:0] x);
        return (x > 8'd64 && x < 8'd91) || (x > 8'd96 && x < 8'd123);
    endfunction

    function automatic logic is_digit(input logic [7:0] x);
        return x > 8'd47 && x < 8'd58;
    endfunction

    function automatic logic glue_before(input logic [7:0] x);
        return x == 8'h3E || x == 8'h23 || x == 8'h25 || x == 8'h24 || x == 8'h5E ||
               x == 8'h7E || x == 8'h29 || x == 8'h5D || x == 8'h7D || x == 8'h7C;
    endfunction

    function automatic logic glue_after(input logic [7:0] x);
        return x == 8'h3C || x == 8'h23 || x == 8'h25 || x == 8'h24 || x == 8'h5E ||
               x == 8'h7E || x == 8'h28 || x == 8'h5B || x == 8'h7B || x == 8'h7C;
    endfunction

    // Rating of byte c from its predecessor p and successors n1, n2 (h* = present)
    function automatic t_rating rate(
        input logic [7:0] c,
        input logic       hp,
        input logic [7:0] p,
        input logic       h1,
        input logic [7:0] n1,
        input logic       h2,
        input logic [7:0] n2
    );
        t_rating r;
        logic    punct;
        logic    space;
        punct = c == 8'h2E || c == 8'h3B || c == 8'h21 || c == 8'h3F;
        space = n1 == 8'h20 || n1 == 8'h09 || n1 == 8'h0A;
        if ((c > 8'd0 && c < 8'd9) || (c > 8'd13 && c < 8'd32)) begin
            r = R_CTRL;
        end else if (h1 && h2 && c == n1 && n1 == n2) begin
            r = R_TRIP;
        end else if (h1 && c == n1) begin
            r = R_PAIR;
        end else if (is_digit(c) || is_letter(c)) begin
            if (h1 && hp && is_digit(c) && is_letter(n1)) begin
                r = R_GLUE;
            end else if (hp && glue_before(p)) begin
                r = R_GLUE;
            end else if (h1 && glue_after(n1)) begin
                r = R_GLUE;
            end else begin
                r = R_WORD;
            end
        end else if (h1 && punct && !space) begin
            r = R_PUNCT;
        end else begin
            r = R_NONE;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pls_front.sv =====
// Front part: three-byte window, rates bytes as their neighbours arrive.
// Depends on pls_pkg; issues one t_work request per accepted byte.
module pls_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output pls_pkg::t_work  o_work
);

    logic [7:0] r_w0, r_w1, r_w2;
    logic [1:0] r_fill;
    logic       r_first;

    logic [7:0] n_w0, n_w1, n_w2;
    logic [1:0] n_fill;
    logic       n_first;

    logic             fill2, k2;
    logic [7:0]       q0, pbase;
    logic             hp0;
    pls_pkg::t_rating d_full, d_t0, d_t1;

    // Window view after the optional full rating
    assign fill2 = r_fill[1];
    assign k2    = r_fill != 2'd0;
    assign q0    = fill2 ? r_w2 : (k2 ? r_w1 : i_data_byte);
    assign pbase = fill2 ? r_w1 : r_w0;
    assign hp0   = fill2 ? 1'b1 : !r_first;

    // Three independent raters
    assign d_full = pls_pkg::rate(r_w1, !r_first, r_w0, 1'b1, r_w2, 1'b1, i_data_byte);
    assign d_t0   = pls_pkg::rate(q0, hp0, pbase, k2, k2 ? i_data_byte : 8'd0,
                                  1'b0, 8'd0);
    assign d_t1   = pls_pkg::rate(i_data_byte, 1'b1, q0, 1'b0, 8'd0, 1'b0, 8'd0);

    // Pack valid ratings from slot 0 in processing order
    always_comb begin
        o_work.last = i_last_byte;
        o_work.d    = '0;
        o_work.n    = 2'd0;
        if (i_last_byte) begin
            if (fill2) begin
                o_work.d = {d_t1, d_t0, d_full};
                o_work.n = 2'd3;
            end else if (k2) begin
                o_work.d = {pls_pkg::R_NONE, d_t1, d_t0};
                o_work.n = 2'd2;
            end else begin
                o_work.d = {pls_pkg::R_NONE, pls_pkg::R_NONE, d_t0};
                o_work.n = 2'd1;
            end
        end else if (fill2) begin
            o_work.d = {pls_pkg::R_NONE, pls_pkg::R_NONE, d_full};
            o_work.n = 2'd1;
        end
    end

    // Window update
    always_comb begin
        n_w0    = r_w0;
        n_w1    = r_w1;
        n_w2    = r_w2;
        n_fill  = r_fill;
        n_first = r_first;
        if (i_accept) begin
            if (i_last_byte) begin
                n_w0    = 8'd0;
                n_w1    = 8'd0;
                n_w2    = 8'd0;
                n_fill  = 2'd0;
                n_first = 1'b1;
            end else begin
                if (fill2) begin
                    n_w0    = r_w1;
                    n_first = 1'b0;
                end
                n_w1   = q0;
                n_w2   = k2 ? i_data_byte : 8'd0;
                n_fill = k2 ? 2'd2 : 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0    <= 8'd0;
            r_w1    <= 8'd0;
            r_w2    <= 8'd0;
            r_fill  <= 2'd0;
            r_first <= 1'b1;
        end else begin
            r_w0    <= n_w0;
            r_w1    <= n_w1;
            r_w2    <= n_w2;
            r_fill  <= n_fill;
            r_first <= n_first;
        end
    end

endmodule

// ===== rtl/pls_queue.sv =====
// Short request queue that decouples the front from the back.
// Depends on pls_pkg for t_work and the depth constants.
module pls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  pls_pkg::t_work  i_work,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output pls_pkg::t_work  o_work
);

    pls_pkg::t_work r_mem [pls_pkg::QDEPTH];
    logic [pls_pkg::QAW-1:0] r_wp, r_rp;
    logic [pls_pkg::QAW:0]   r_cnt;

    logic do_wr, do_rd;

    assign o_full  = r_cnt == (pls_pkg::QAW+1)'(pls_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_work  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_work;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/pls_back.sv =====
// Back: saturating accumulator, one rating a cycle unless held, result register.
// Depends on pls_pkg for t_work and the saturation bound.
module pls_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pls_pkg::t_work      i_work,
    output logic                o_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output logic signed [20:0]  o_score,
    output logic                o_clipped
);

    localparam logic signed [21:0] BND = 22'(pls_pkg::BOUND);

    logic signed [20:0] r_score, n_score;
    logic               r_flag, n_flag;
    logic [1:0]         r_step;
    logic               r_out_valid;
    logic signed [20:0] r_out_score;
    logic               r_out_clip;

    logic               have, done, go, out_free;
    logic signed [21:0] sum;
    pls_pkg::t_rating   d_cur;

    assign out_free = !r_out_valid || i_pop;
    assign d_cur    = i_work.d[r_step];
    assign have     = {1'b0, r_step} < {1'b0, i_work.n};
    assign done     = ({1'b0, r_step} + 3'd1) >= {1'b0, i_work.n};
    assign go       = i_valid && (!(done && i_work.last) || out_free);
    assign o_rd     = go && done;

    // Saturating add of the current rating
    always_comb begin
        sum     = {r_score[20], r_score} + 22'(d_cur);
        n_score = r_score;
        n_flag  = r_flag;
        if (have) begin
            if (sum > BND) begin
                n_score = 21'(BND);
                n_flag  = 1'b1;
            end else if (sum < -BND) begin
                n_score = 21'(-BND);
                n_flag  = 1'b1;
            end else begin
                n_score = sum[20:0];
            end
        end
    end

    // Accumulator and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_flag  <= 1'b0;
            r_step  <= 2'd0;
        end else if (go) begin
            if (done) begin
                r_step <= 2'd0;
            end else begin
                r_step <= r_step + 2'd1;
            end
            if (done && i_work.last) begin
                r_score <= '0;
                r_flag  <= 1'b0;
            end else begin
                r_score <= n_score;
                r_flag  <= n_flag;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && done && i_work.last) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && done && i_work.last) begin
            r_out_score <= n_score;
            r_out_clip  <= n_flag;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_score   = r_out_score;
    assign o_clipped = r_out_clip;

endmodule

// ===== rtl/plaintext_likelihood_scorer_core.sv =====
// Plaintext likelihood scorer: one byte per cycle unless full, one score per buffer.
// Result: the score is registered once the back has added the last byte's ratings,
// and waits behind any requests queued ahead of it.
// Throughput: one byte a cycle unless full; the back spends extra steps on a buffer's
// last ratings, so full rises when short buffers follow closely on each other.
// Reset: synchronous, active low; clears window, queue, accumulator and result.
module plaintext_likelihood_scorer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic signed [20:0] o_score,
    output logic               o_clipped
);

    pls_pkg::t_work f_work, q_work;
    logic           accept, q_valid, q_rd;

    assign accept = push && !full;

    // Front: window and raters
    pls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_work      (f_work)
    );

    // Decoupling queue
    pls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_work  (f_work),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // Back: accumulator and result register
    pls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_work    (q_work),
        .o_rd      (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_score   (o_score),
        .o_clipped (o_clipped)
    );

endmodule

// ===== rtl/pls_checker.sv =====
// Port-level checks for the plaintext scorer, bound onto the top level.
// Depends on pls_pkg for the saturation bound.
module pls_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [20:0] o_score,
    input  logic               o_clipped
);

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_score) && $stable(o_clipped)))
        else $error("result changed while waiting");

    // Score never leaves the saturation range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_score <= 21'(pls_pkg::BOUND) && o_score >= -21'(pls_pkg::BOUND)))
        else $error("score outside bound");

    // Reset leaves both sides idle
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

endmodule

bind plaintext_likelihood_scorer_core pls_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_score   (o_score),
    .o_clipped (o_clipped)
);

// ===== tb/plaintext_likelihood_scorer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for plaintext_likelihood_scorer_core: streams byte buffers in,
// predicts each buffer's total score and saturation flag, and checks every result popped.
// Depends only on the RTL under rtl/ (pls_pkg and plaintext_likelihood_scorer_core).
module plaintext_likelihood_scorer_core_tb;

    localparam int SCORE_LIMIT  = 655360;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 875;

    typedef struct {
        int score;
        bit clip;
    } total_t;

    typedef struct {
        logic [7:0] b;
        bit         lst;
        bit         typed;
        int         score;
        bit         clip;
    } stim_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic               empty;
    logic               pop;
    logic signed [20:0] o_score;
    logic               o_clipped;

    plaintext_likelihood_scorer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_score     (o_score),
        .o_clipped   (o_clipped)
    );

    // Predictor state: last rated byte, up to two bytes awaiting their successors
    logic [7:0] prev_byte;
    logic [7:0] held [2];
    int         held_n;
    bit         prev_valid;
    int         acc;
    bit         hit_bound;

    total_t totals_due [$];
    int     errors    = 0;
    int     cycles    = 0;
    int     n_buffers = 0;
    int     n_bytes   = 0;
    int     n_checked = 0;
    logic   calm;

    // Directed buffers; single-byte ones carry their score typed in
    stim_row_t stim_rows [25] = '{
        '{"A",   1, 1, 10, 0},
        '{8'h01, 1, 1, -4, 0},
        '{8'hFF, 1, 1, 0,  0},
        '{8'h00, 1, 1, 0,  0},
        '{"z",   1, 1, 10, 0},
        '{"a",   0, 0, 0,  0},
        '{"a",   0, 0, 0,  0},
        '{"a",   1, 0, 0,  0},
        '{"1",   0, 0, 0,  0},
        '{"a",   1, 0, 0,  0},
        '{"x",   0, 0, 0,  0},
        '{"1",   0, 0, 0,  0},
        '{"a",   1, 0, 0,  0},
        '{"$",   0, 0, 0,  0},
        '{"a",   1, 0, 0,  0},
        '{"a",   0, 0, 0,  0},
        '{"(",   1, 0, 0,  0},
        '{".",   0, 0, 0,  0},
        '{"x",   1, 0, 0,  0},
        '{"!",   0, 0, 0,  0},
        '{" ",   1, 0, 0,  0},
        '{8'h1F, 0, 0, 0,  0},
        '{8'h0E, 0, 0, 0,  0},
        '{8'h09, 0, 0, 0,  0},
        '{8'h80, 1, 0, 0,  0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_window();
        prev_byte  = 8'h00;
        held[0]    = 8'h00;
        held[1]    = 8'h00;
        held_n     = 0;
        prev_valid = 0;
        acc        = 0;
        hit_bound  = 0;
    endfunction

    // Merit of one byte c given its neighbours (h* says the neighbour exists)
    function automatic int byte_merit(input logic [7:0] c, input bit hp, input logic [7:0] p,
                                      input bit h1, input logic [7:0] n1,
                                      input bit h2, input logic [7:0] n2);
        bit digit;
        bit alnum;
        bit next_letter;
        bit glue_prev;
        bit glue_next;
        bit stop;
        bit gap;
        digit       = c >= "0" && c <= "9";
        alnum       = digit || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        next_letter = (n1 >= "A" && n1 <= "Z") || (n1 >= "a" && n1 <= "z");
        stop        = c == "." || c == ";" || c == "!" || c == "?";
        gap         = n1 == " " || n1 == 8'h09 || n1 == 8'h0A;
        case (p)
            ">", "#", "%", "$", "^", "~", ")", "]", "}", "|": glue_prev = 1;
            default: glue_prev = 0;
        endcase
        case (n1)
            "<", "#", "%", "$", "^", "~", "(", "[", "{", "|": glue_next = 1;
            default: glue_next = 0;
        endcase
        // control characters, tab to CR excluded
        if ((c >= 8'h01 && c <= 8'h08) || (c >= 8'h0E && c <= 8'h1F))
            return -4;
        if (h1 && c == n1)
            return (h2 && n2 == c) ? -5 : -2;
        if (alnum) begin
            if ((h1 && hp && digit && next_letter) || (hp && glue_prev) || (h1 && glue_next))
                return -10;
            return 10;
        end
        if (h1 && stop && !gap)
            return -2;
        return 0;
    endfunction

    function automatic void add_merit(input int d);
        acc = acc + d;
        if (acc > SCORE_LIMIT) begin
            acc       = SCORE_LIMIT;
            hit_bound = 1;
        end
        if (acc < -SCORE_LIMIT) begin
            acc       = -SCORE_LIMIT;
            hit_bound = 1;
        end
    endfunction

    // Advance the predictor by one accepted byte; a last byte yields the buffer total
    task automatic predict_byte(input logic [7:0] b, input bit lst,
                                output bit got, output total_t t);
        logic [7:0] w [3];
        int         k;
        w[1] = 8'h00;
        w[2] = 8'h00;
        k    = 0;
        got  = 0;
        t    = '{0, 0};
        for (int j = 0; j < held_n; j++) begin
            w[k] = held[j];
            k++;
        end
        w[k] = b;
        k++;
        // oldest held byte now has both successors
        if (k == 3) begin
            add_merit(byte_merit(w[0], prev_valid, prev_byte, 1, w[1], 1, w[2]));
            prev_byte  = w[0];
            prev_valid = 1;
            w[0] = w[1];
            w[1] = w[2];
            k    = 2;
        end
        if (!lst) begin
            held[0] = w[0];
            held[1] = w[1];
            held_n  = k;
        end else begin
            for (int j = 0; j < k; j++)
                add_merit(byte_merit(w[j], j > 0 || prev_valid, j > 0 ? w[j - 1] : prev_byte,
                                     j + 1 < k, (j + 1 < k) ? w[j + 1] : 8'h00,
                                     j + 2 < k, (j + 2 < k) ? w[j + 2] : 8'h00));
            t.score = acc;
            t.clip  = hit_bound;
            got     = 1;
            clear_window();
        end
    endtask

    // One request: optional random gap, then hold push until accepted
    task automatic push_byte(input logic [7:0] b, input bit lst, input bit typed,
                             input int tscore, input bit tclip);
        bit     got;
        total_t t;
        while (!calm && $urandom_range(99, 0) < 12) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_byte(b, lst, got, t);
        n_bytes++;
        if (got) begin
            if (typed) begin
                t.score = tscore;
                t.clip  = tclip;
            end
            totals_due.insert(totals_due.size(), t);
            n_buffers++;
        end
    endtask

    // Stop sending until every buffer total has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (totals_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    // Random byte, biased towards text and towards the rating rules
    function automatic logic [7:0] pick_byte(input logic [7:0] prev);
        string stops;
        string gaps;
        string glue;
        stops = ".;!?";
        gaps  = " \t\n";
        glue  = "<>#%$^~()[]{}|";
        case ($urandom_range(9, 0))
            0, 1, 2: return $urandom_range(1, 0) ? 8'($urandom_range(90, 65))
                                                 : 8'($urandom_range(122, 97));
            3:       return 8'($urandom_range(57, 48));
            4:       return stops[$urandom_range(stops.len() - 1, 0)];
            5:       return gaps[$urandom_range(gaps.len() - 1, 0)];
            6:       return glue[$urandom_range(glue.len() - 1, 0)];
            7:       return prev;
            8:       return 8'($urandom_range(31, 0));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // Result side: random pop stalls, none while calm
    always @(posedge i_clk)
        pop <= i_rst_n && (calm || $urandom_range(99, 0) >= 12);

    // Compare each popped total with the oldest one due
    always @(posedge i_clk) begin : check_totals
        total_t want;
        if (i_rst_n && pop && !empty) begin
            if (totals_due.size() == 0) begin
                report_mismatch("score with no buffer due", o_score, 0);
            end else begin
                want = totals_due.pop_front();
                n_checked++;
                if (o_score !== want.score[20:0])
                    report_mismatch("score", o_score, want.score);
                if (o_clipped !== want.clip)
                    report_mismatch("clipped", o_clipped, want.clip);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d with %0d totals due", cycles, totals_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] b;
        logic [7:0] last_b;
        int         len;
        int         sent;
        bit         paused;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        calm        <= 1'b0;
        clear_window();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers
        foreach (stim_rows[r])
            push_byte(stim_rows[r].b, stim_rows[r].lst, stim_rows[r].typed,
                      stim_rows[r].score, stim_rows[r].clip);
        drain();

        // Random buffers, mostly short
        sent   = 0;
        paused = 0;
        last_b = 8'h00;
        while (sent < RANDOM_BYTES) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
            for (int i = 0; i < len; i++) begin
                b = pick_byte(last_b);
                push_byte(b, i == len - 1, 0, 0, 0);
                last_b = b;
                sent++;
                calm <= (sent >= 300 && sent < 500);
            end
            if (sent >= 450 && !paused) begin
                drain();
                paused = 1;
            end
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d of %0d buffer totals over %0d bytes", n_checked, n_buffers,
                 n_bytes);
        $display("Directed rating cases, random text-like buffers, stalls on both sides");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== plaintext_likelihood_scorer_core.f =====
rtl/pls_pkg.sv
rtl/pls_front.sv
rtl/pls_queue.sv
rtl/pls_back.sv
rtl/plaintext_likelihood_scorer_core.sv
rtl/pls_checker.sv
tb/plaintext_likelihood_scorer_core_tb.sv
